### rtl/nss_pkg.sv
// nss_pkg: shared types, codes and digit helpers for the nixie scroll sequencer
// no dependencies; used by nixie_scroll_sequencer
package nss_pkg;

	typedef enum logic [1:0] {
		OP_DIRECT = 2'd0,
		OP_SCROLL = 2'd1,
		OP_RAW    = 2'd2,
		OP_TICK   = 2'd3
	} op_t;

	localparam int unsigned DIGITS = 6;
	localparam logic [2:0] LAST_DIGIT = 3'd5;
	localparam logic [2:0] NO_LIMIT = 3'd6;
	localparam logic [7:0] BLANK = 8'd255;
	localparam logic [4:0] SETTLE_MIN = 5'd11;
	localparam logic [15:0] STEP_TICKS_RESET = 16'd15;

	typedef struct packed {
		op_t        op;
		logic [7:0] hours;
		logic [7:0] minutes;
		logic [7:0] seconds;
		logic [7:0] divider;
	} nss_in_t;

	typedef struct packed {
		logic [7:0] hours_byte;
		logic [7:0] minutes_byte;
		logic [7:0] seconds_byte;
		logic [7:0] divider_byte;
		logic       in_scroll;
	} nss_out_t;

	// n / 10 via reciprocal, exact for 8-bit n
	function automatic logic [4:0] div10(input logic [7:0] n);
		logic [15:0] prod;
		prod = 16'(n) * 16'd205;
		return prod[15:11];
	endfunction

	function automatic logic [3:0] mod10_5(input logic [4:0] v);
		logic [4:0] r;
		if (v >= 5'd30)
			r = v - 5'd30;
		else if (v >= 5'd20)
			r = v - 5'd20;
		else if (v >= 5'd10)
			r = v - 5'd10;
		else
			r = v;
		return r[3:0];
	endfunction

	function automatic logic [3:0] tens_digit(input logic [7:0] n);
		return mod10_5(div10(n));
	endfunction

	function automatic logic [3:0] units_digit(input logic [7:0] n);
		logic [7:0] q;
		logic [7:0] r;
		q = {3'b000, div10(n)};
		r = n - (q << 3) - (q << 1);
		return r[3:0];
	endfunction

	function automatic logic [7:0] pair_byte(input logic [7:0] n);
		if (n == BLANK)
			return BLANK;
		return {units_digit(n), tens_digit(n)};
	endfunction

endpackage

### rtl/nixie_scroll_sequencer.sv
// nixie_scroll_sequencer: frame generator for three nixie tube pairs and a divider lamp
// depends on nss_pkg
//
// usage:
//  input channel in_valid/in_stall/in_data carries ops: direct time, scrolled time,
//  raw bytes and tick. output channel out_valid/out_stall/out_data carries frames.
//  a transfer happens at a clock edge with valid high and stall low.
//  cfg_we/cfg_wdata write step_ticks, the tick count waited after each scroll frame;
//  write it only while no scroll is running.
//  path: an item passes the input register, then the result register, from which its
//  frame is offered. one item is taken every cycle while in_stall is low; all per-item
//  work is one pass of digit logic between the two registers.
//  a scroll steps one digit per frame and emits the next frame only on ticks;
//  other requests are dropped while a scroll runs.
//  reset (arst_n low) clears the stored time to zero, step_ticks to 15, ends any
//  scroll and empties both registers.
//  when out_stall is high the result holds and in_stall rises once the input
//  register is also full; no transfer is lost.
module nixie_scroll_sequencer (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  nss_pkg::nss_in_t  in_data,
	output logic            out_valid,
	input  logic            out_stall,
	output nss_pkg::nss_out_t out_data,
	input  logic            cfg_we,
	input  logic [15:0]     cfg_wdata
);
	import nss_pkg::*;

	logic        vld_s1;
	nss_in_t     in_s1;
	logic        out_valid_q;
	nss_out_t    out_q;
	logic        adv;

	logic [15:0] step_ticks_q;
	logic [7:0]  shown_h_q, shown_m_q, shown_s_q;
	logic [23:0] pending_q;
	logic [3:0]  tgt_q [DIGITS];
	logic [4:0]  cnt_q [DIGITS];
	logic [2:0]  ptr_q;
	logic [7:0]  held_div_q;
	logic [15:0] wait_q;
	logic        busy_q;

	logic [3:0]  fresh_tgt [DIGITS];
	logic [3:0]  fresh_cnt [DIGITS];
	logic [3:0]  tgt_w [DIGITS];
	logic [4:0]  cnt_w [DIGITS];
	logic [4:0]  cnt_nx [DIGITS];
	logic [3:0]  shown_dig [DIGITS];
	logic [DIGITS-1:0] diff, needs;
	logic [2:0]  p_cur, lim, sel_srch, sel;
	logic        found, stay, do_step;
	logic [15:0] wait_load;

	logic        start_scroll, scroll_tick, wait_dec, take_step, do_finish;
	logic        emit;
	nss_out_t    res;

	assign adv = !out_valid_q || !out_stall;
	assign in_stall = vld_s1 && !adv;
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	// digit views of new and stored time
	always_comb begin
		fresh_tgt[0] = tens_digit(in_s1.hours);
		fresh_tgt[1] = units_digit(in_s1.hours);
		fresh_tgt[2] = tens_digit(in_s1.minutes);
		fresh_tgt[3] = units_digit(in_s1.minutes);
		fresh_tgt[4] = tens_digit(in_s1.seconds);
		fresh_tgt[5] = units_digit(in_s1.seconds);
		shown_dig[0] = tens_digit(shown_h_q);
		shown_dig[1] = units_digit(shown_h_q);
		shown_dig[2] = tens_digit(shown_m_q);
		shown_dig[3] = units_digit(shown_m_q);
		shown_dig[4] = tens_digit(shown_s_q);
		shown_dig[5] = units_digit(shown_s_q);
		for (int i = 0; i < DIGITS; i++) begin
			fresh_cnt[i] = shown_dig[i];
		end
	end

	// step selection
	always_comb begin
		p_cur = (ptr_q > LAST_DIGIT) ? LAST_DIGIT : ptr_q;
		for (int i = 0; i < DIGITS; i++) begin
			tgt_w[i] = busy_q ? tgt_q[i] : fresh_tgt[i];
			cnt_w[i] = busy_q ? cnt_q[i] : {1'b0, fresh_cnt[i]};
			diff[i] = cnt_w[i] != {1'b0, tgt_w[i]};
			needs[i] = (mod10_5(cnt_w[i]) != tgt_w[i]) || (cnt_w[i] < SETTLE_MIN);
		end
		stay = busy_q && needs[p_cur];
		lim = busy_q ? p_cur : NO_LIMIT;
		found = 1'b0;
		sel_srch = LAST_DIGIT;
		for (int i = 0; i < DIGITS; i++) begin
			if (diff[i] && (3'(i) < lim)) begin
				found = 1'b1;
				sel_srch = 3'(i);
			end
		end
		sel = stay ? p_cur : sel_srch;
		do_step = stay || found;
		for (int i = 0; i < DIGITS; i++) begin
			cnt_nx[i] = (3'(i) == sel) ? cnt_w[i] + 5'd1 : cnt_w[i];
		end
		wait_load = (step_ticks_q == 16'd0) ? 16'd1 : step_ticks_q;
	end

	// item decode
	always_comb begin
		start_scroll = vld_s1 && !busy_q && (in_s1.op == OP_SCROLL);
		scroll_tick  = vld_s1 && busy_q && (in_s1.op == OP_TICK);
		wait_dec     = scroll_tick && (wait_q > 16'd1);
		take_step    = (start_scroll || (scroll_tick && !wait_dec)) && do_step;
		do_finish    = (start_scroll || (scroll_tick && !wait_dec)) && !do_step;
		emit = 1'b0;
		res = '0;
		if (take_step) begin
			emit = 1'b1;
			res.hours_byte   = {mod10_5(cnt_nx[1]), mod10_5(cnt_nx[0])};
			res.minutes_byte = {mod10_5(cnt_nx[3]), mod10_5(cnt_nx[2])};
			res.seconds_byte = {mod10_5(cnt_nx[5]), mod10_5(cnt_nx[4])};
			res.divider_byte = busy_q ? held_div_q : in_s1.divider;
			res.in_scroll    = 1'b1;
		end else if (vld_s1 && !busy_q) begin
			case (in_s1.op)
				OP_DIRECT: begin
					emit = 1'b1;
					res.hours_byte   = pair_byte(in_s1.hours);
					res.minutes_byte = pair_byte(in_s1.minutes);
					res.seconds_byte = pair_byte(in_s1.seconds);
					res.divider_byte = in_s1.divider;
				end
				OP_RAW: begin
					emit = 1'b1;
					res.hours_byte   = in_s1.hours;
					res.minutes_byte = in_s1.minutes;
					res.seconds_byte = in_s1.seconds;
					res.divider_byte = in_s1.divider;
				end
				default: begin
					emit = 1'b0;
				end
			endcase
		end
	end

	// input and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (!in_stall)
				vld_s1 <= in_valid;
			if (adv)
				out_valid_q <= vld_s1 && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall)
			in_s1 <= in_data;
		if (adv && vld_s1 && emit)
			out_q <= res;
	end

	// scroll control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_ticks_q <= STEP_TICKS_RESET;
			shown_h_q <= '0;
			shown_m_q <= '0;
			shown_s_q <= '0;
			ptr_q <= LAST_DIGIT;
			wait_q <= '0;
			busy_q <= 1'b0;
		end else begin
			if (cfg_we)
				step_ticks_q <= cfg_wdata;
			if (adv) begin
				if (wait_dec) begin
					wait_q <= wait_q - 16'd1;
				end else if (take_step) begin
					busy_q <= 1'b1;
					ptr_q <= sel;
					wait_q <= wait_load;
				end else if (do_finish) begin
					busy_q <= 1'b0;
					ptr_q <= LAST_DIGIT;
					wait_q <= '0;
					if (start_scroll) begin
						shown_h_q <= in_s1.hours;
						shown_m_q <= in_s1.minutes;
						shown_s_q <= in_s1.seconds;
					end else begin
						shown_h_q <= pending_q[23:16];
						shown_m_q <= pending_q[15:8];
						shown_s_q <= pending_q[7:0];
					end
				end
			end
		end
	end

	// scroll working set
	always_ff @(posedge clk) begin
		if (adv) begin
			if (start_scroll) begin
				pending_q <= {in_s1.hours, in_s1.minutes, in_s1.seconds};
				held_div_q <= in_s1.divider;
				for (int i = 0; i < DIGITS; i++) begin
					tgt_q[i] <= fresh_tgt[i];
				end
			end
			if (take_step) begin
				for (int i = 0; i < DIGITS; i++) begin
					cnt_q[i] <= cnt_nx[i];
				end
			end
		end
	end

	a_wait_only_busy: assert property (@(posedge clk) disable iff (!arst_n)
		wait_q != 16'd0 |-> busy_q)
		else $error("wait count running while idle");

	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> ptr_q <= LAST_DIGIT)
		else $error("digit pointer out of range during scroll");

	a_scroll_frame_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.in_scroll |-> busy_q)
		else $error("scroll frame pending without a running scroll");

	a_busy_step_waits: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy_q) |-> wait_q != 16'd0)
		else $error("scroll started without a wait count");

endmodule
